// File: design/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg: shared types and codes of the modem power sequencer
// Phase, outcome and pin codes, configuration register indexes and the
// structs that pass configuration and pin levels between modules.
// ----------------------------------------------------------------------------
package mps_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_BOOT_MODE   = 3'd0;
   localparam logic [2:0] CSR_FIRST_WAIT  = 3'd1;
   localparam logic [2:0] CSR_RETRY_WAIT  = 3'd2;
   localparam logic [2:0] CSR_PU_TRIES    = 3'd3;
   localparam logic [2:0] CSR_PU_GAP      = 3'd4;
   localparam logic [2:0] CSR_SETTLE      = 3'd5;
   localparam logic [2:0] CSR_PANIC_POLLS = 3'd6;
   localparam logic [2:0] CSR_PANIC_TICKS = 3'd7;

   // Commands
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_UP    = 2'd1;
   localparam logic [1:0] CMD_DOWN  = 2'd2;
   localparam logic [1:0] CMD_BAD   = 2'd3;

   // Sequencer phases
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_PU_RESIN = 3'd1;
   localparam logic [2:0] PH_PU_PWRON = 3'd2;
   localparam logic [2:0] PH_PU_PULSE = 3'd3;
   localparam logic [2:0] PH_PU_POLL  = 3'd4;
   localparam logic [2:0] PH_SD_PWRON = 3'd5;
   localparam logic [2:0] PH_SD_ENTER = 3'd6;
   localparam logic [2:0] PH_SD_WAIT  = 3'd7;

   // Pin codes
   localparam logic [2:0] AP_NO_BYPASS    = 3'h3;
   localparam logic [2:0] AP_SHUTDOWN_REQ = 3'h4;
   localparam logic [2:0] AP_UNDEFINED    = 3'h7;
   localparam logic [2:0] ST_PANIC        = 3'h0;
   localparam logic [2:0] ST_SHUTDOWN_ACK = 3'h6;
   localparam logic [2:0] ST_UNDEFINED    = 3'h7;

   // Outcomes
   localparam logic [2:0] OC_NONE        = 3'd0;
   localparam logic [2:0] OC_UP          = 3'd1;
   localparam logic [2:0] OC_UP_TIMEOUT  = 3'd2;
   localparam logic [2:0] OC_OFF         = 3'd3;
   localparam logic [2:0] OC_OFF_FAILED  = 3'd4;
   localparam logic [2:0] OC_ALREADY_OFF = 3'd5;
   localparam logic [2:0] OC_REJECTED    = 3'd6;

   typedef struct packed {
      logic       boot_mode;
      logic [9:0] first_wait_ticks;
      logic [9:0] retry_wait_ticks;
      logic [7:0] powerup_tries;
      logic [7:0] powerup_gap_ticks;
      logic [7:0] settle_ticks;
      logic [7:0] panic_hold_polls;
      logic [7:0] panic_poll_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] host_state;
      logic       pwron;
      logic       resin;
      logic       boot;
      logic       boot_driven;
   } pins_type;

   // Treat a zero tick delay as one tick
   function automatic logic [7:0] at_least_one(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

endpackage

// File: design/modem_power_sequencer.sv
// ----------------------------------------------------------------------------
// modem_power_sequencer: companion modem power sequencing
// Top level: configuration registers, status latch, sequencer, result register.
// ----------------------------------------------------------------------------
// Each request transfer is one 100 ms tick carrying the sampled modem status
// pins, the reset-out pin and an optional command (power-up or shutdown). Every
// request produces exactly one response transfer showing the pin levels, the
// latched modem status and power state, busy, and the sequence outcome after
// that tick. Throughput is one transfer per clock: the state update is a
// single pass of logic from the request port and current state into the
// response register, and the block accepts a new request whenever the response
// register is empty or is being taken in the same cycle.
// Write configuration registers only while no transfer is outstanding.
// ----------------------------------------------------------------------------
module modem_power_sequencer (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [2:0] req_status_pins,
   input  logic       req_resout_pin,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_ap_status_pins,
   output logic       rsp_pwron_pin,
   output logic       rsp_resin_pin,
   output logic       rsp_boot_pins,
   output logic       rsp_boot_pins_driven,
   output logic       rsp_busy_res,
   output logic [2:0] rsp_outcome,
   output logic [2:0] rsp_modem_status,
   output logic       rsp_modem_on,
   output logic       rsp_status_event,
   // configuration write port
   input  logic       csr_write_en,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_wdata
);

   mps_pkg::cfg_type  cfg;
   mps_pkg::pins_type pins_in;
   mps_pkg::pins_type pins_ff;
   logic              advance;
   logic              busy_in, busy_ff;
   logic [2:0]        outcome_in, outcome_ff;
   logic [2:0]        status_in, status_ff;
   logic              power_in, power_ff;
   logic              event_in, event_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // Take a request when the response slot is free or drains this cycle
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign advance      = req_valid && req_ready;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   mps_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   mps_latch u_latch (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .advance     (advance),
      .status_pins (req_status_pins),
      .resout_pin  (req_resout_pin),
      .status_in   (status_in),
      .power_in    (power_in),
      .event_in    (event_in)
   );

   mps_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .advance     (advance),
      .cmd         (req_cmd),
      .status_pins (req_status_pins),
      .resout_pin  (req_resout_pin),
      .pins_in     (pins_in),
      .busy_in     (busy_in),
      .outcome_in  (outcome_in)
   );

   // Hold the valid flag; clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response payload on each accepted request
   always_ff @(posedge clock) begin
      if (advance) begin
         pins_ff    <= pins_in;
         busy_ff    <= busy_in;
         outcome_ff <= outcome_in;
         status_ff  <= status_in;
         power_ff   <= power_in;
         event_ff   <= event_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ap_status_pins   = pins_ff.host_state;
   assign rsp_pwron_pin        = pins_ff.pwron;
   assign rsp_resin_pin        = pins_ff.resin;
   assign rsp_boot_pins        = pins_ff.boot;
   assign rsp_boot_pins_driven = pins_ff.boot_driven;
   assign rsp_busy_res         = busy_ff;
   assign rsp_outcome          = outcome_ff;
   assign rsp_modem_status     = status_ff;
   assign rsp_modem_on         = power_ff;
   assign rsp_status_event     = event_ff;

endmodule

// File: design/mps_csr.sv
// ----------------------------------------------------------------------------
// mps_csr: configuration registers
// Holds the eight timing and mode registers written through the plain port.
// ----------------------------------------------------------------------------
module mps_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [2:0]           csr_index,
   input  logic [9:0]           csr_wdata,
   output mps_pkg::cfg_type     cfg
);

   mps_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boot_mode         <= 1'b0;
         cfg_ff.first_wait_ticks  <= 10'd50;
         cfg_ff.retry_wait_ticks  <= 10'd70;
         cfg_ff.powerup_tries     <= 8'd10;
         cfg_ff.powerup_gap_ticks <= 8'd4;
         cfg_ff.settle_ticks      <= 8'd1;
         cfg_ff.panic_hold_polls  <= 8'd100;
         cfg_ff.panic_poll_ticks  <= 8'd5;
      end else if (csr_write_en) begin
         case (csr_index)
            mps_pkg::CSR_BOOT_MODE:   cfg_ff.boot_mode         <= csr_wdata[0];
            mps_pkg::CSR_FIRST_WAIT:  cfg_ff.first_wait_ticks  <= csr_wdata;
            mps_pkg::CSR_RETRY_WAIT:  cfg_ff.retry_wait_ticks  <= csr_wdata;
            mps_pkg::CSR_PU_TRIES:    cfg_ff.powerup_tries     <= csr_wdata[7:0];
            mps_pkg::CSR_PU_GAP:      cfg_ff.powerup_gap_ticks <= csr_wdata[7:0];
            mps_pkg::CSR_SETTLE:      cfg_ff.settle_ticks      <= csr_wdata[7:0];
            mps_pkg::CSR_PANIC_POLLS: cfg_ff.panic_hold_polls  <= csr_wdata[7:0];
            mps_pkg::CSR_PANIC_TICKS: cfg_ff.panic_poll_ticks  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/mps_latch.sv
// ----------------------------------------------------------------------------
// mps_latch: modem status and power latch
// Latches status and reset-out on change, holding a panic reading that
// follows the undefined start state for a number of polls.
// ----------------------------------------------------------------------------
module mps_latch (
   input  logic                 clock,
   input  logic                 reset,
   input  mps_pkg::cfg_type     cfg,
   input  logic                 advance,
   input  logic [2:0]           status_pins,
   input  logic                 resout_pin,
   output logic [2:0]           status_in,
   output logic                 power_in,
   output logic                 event_in
);

   logic [2:0] status_ff;
   logic       power_ff;
   logic       holding_ff, holding_in;
   logic [7:0] hold_count_ff, hold_count_in;
   logic [7:0] hold_tick_ff, hold_tick_in;

   always_comb begin
      logic       finish;
      logic       differ;
      logic [7:0] hc;
      finish        = 1'b0;
      differ        = (status_pins != status_ff) || (resout_pin != power_ff);
      hc            = hold_count_ff;
      status_in     = status_ff;
      power_in      = power_ff;
      event_in      = 1'b0;
      holding_in    = holding_ff;
      hold_count_in = hold_count_ff;
      hold_tick_in  = hold_tick_ff;
      if (holding_ff) begin
         if (hold_tick_ff > 8'd1) begin
            hold_tick_in = hold_tick_ff - 8'd1;
         end else begin
            if (hold_count_ff != 8'd0) hc = hold_count_ff - 8'd1;
            hold_count_in = hc;
            if (status_pins != mps_pkg::ST_PANIC || hc == 8'd0) begin
               finish = 1'b1;
            end else begin
               hold_tick_in = mps_pkg::at_least_one(cfg.panic_poll_ticks);
            end
         end
      end else if (differ) begin
         if (status_ff == mps_pkg::ST_UNDEFINED && status_pins == mps_pkg::ST_PANIC &&
             cfg.panic_hold_polls != 8'd0) begin
            // start holding the panic reading
            holding_in    = 1'b1;
            hold_count_in = cfg.panic_hold_polls;
            hold_tick_in  = mps_pkg::at_least_one(cfg.panic_poll_ticks);
         end else begin
            finish = 1'b1;
         end
      end
      if (finish) begin
         event_in      = differ;
         holding_in    = 1'b0;
         hold_count_in = 8'd0;
         hold_tick_in  = 8'd0;
         status_in     = status_pins;
         power_in      = resout_pin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= mps_pkg::ST_UNDEFINED;
         power_ff      <= 1'b0;
         holding_ff    <= 1'b0;
         hold_count_ff <= 8'd0;
         hold_tick_ff  <= 8'd0;
      end else if (advance) begin
         status_ff     <= status_in;
         power_ff      <= power_in;
         holding_ff    <= holding_in;
         hold_count_ff <= hold_count_in;
         hold_tick_ff  <= hold_tick_in;
      end
   end

endmodule

// File: design/mps_seq.sv
// ----------------------------------------------------------------------------
// mps_seq: power-up and shutdown sequencer
// Phase machine with settle counter and poll counter driving the modem pins.
// ----------------------------------------------------------------------------
module mps_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  mps_pkg::cfg_type     cfg,
   input  logic                 advance,
   input  logic [1:0]           cmd,
   input  logic [2:0]           status_pins,
   input  logic                 resout_pin,
   output mps_pkg::pins_type    pins_in,
   output logic                 busy_in,
   output logic [2:0]           outcome_in
);

   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        delay_ff, delay_in;
   logic [9:0]        loop_ff, loop_in;
   logic              ack_ff, ack_in;
   logic              retry_ff, retry_in;
   mps_pkg::pins_type pins_ff;

   always_comb begin
      logic [7:0] settle1;
      logic [9:0] tries;
      logic [9:0] lp;
      logic [9:0] lp_next;
      logic       ack;
      logic [9:0] limit;
      settle1    = mps_pkg::at_least_one(cfg.settle_ticks);
      tries      = {2'b00, cfg.powerup_tries};
      lp         = loop_ff;
      lp_next    = 10'd0;
      ack        = ack_ff;
      limit      = retry_ff ? cfg.retry_wait_ticks : cfg.first_wait_ticks;
      phase_in   = phase_ff;
      delay_in   = delay_ff;
      loop_in    = loop_ff;
      ack_in     = ack_ff;
      retry_in   = retry_ff;
      pins_in    = pins_ff;
      outcome_in = mps_pkg::OC_NONE;

      if (cmd == mps_pkg::CMD_BAD ||
          (cmd != mps_pkg::CMD_TICK && phase_ff != mps_pkg::PH_IDLE)) begin
         outcome_in = mps_pkg::OC_REJECTED;
      end else if (cmd == mps_pkg::CMD_UP) begin
         pins_in.boot        = cfg.boot_mode;
         pins_in.boot_driven = 1'b1;
         pins_in.host_state  = mps_pkg::AP_NO_BYPASS;
         phase_in            = mps_pkg::PH_PU_RESIN;
         delay_in            = settle1;
      end else if (cmd == mps_pkg::CMD_DOWN) begin
         if (!resout_pin) begin
            outcome_in = mps_pkg::OC_ALREADY_OFF;
         end else begin
            pins_in.host_state = mps_pkg::AP_SHUTDOWN_REQ;
            ack_in             = 1'b0;
            retry_in           = 1'b0;
            phase_in           = mps_pkg::PH_SD_PWRON;
            delay_in           = settle1;
         end
      end else if (phase_ff != mps_pkg::PH_IDLE) begin
         if (delay_ff > 8'd1) begin
            delay_in = delay_ff - 8'd1;
         end else begin
            case (phase_ff)
               mps_pkg::PH_PU_RESIN: begin
                  pins_in.resin = 1'b0;
                  phase_in      = mps_pkg::PH_PU_PWRON;
                  delay_in      = settle1;
               end
               mps_pkg::PH_PU_PWRON: begin
                  pins_in.pwron = 1'b1;
                  phase_in      = mps_pkg::PH_PU_PULSE;
                  delay_in      = settle1;
               end
               mps_pkg::PH_PU_PULSE, mps_pkg::PH_PU_POLL: begin
                  // end the pulse and take a reset-out sample
                  if (phase_ff == mps_pkg::PH_PU_PULSE) begin
                     pins_in.pwron = 1'b0;
                     lp            = 10'd0;
                  end
                  lp_next = lp + 10'd1;
                  loop_in = lp;
                  if (lp >= tries) begin
                     phase_in   = mps_pkg::PH_IDLE;
                     outcome_in = mps_pkg::OC_UP_TIMEOUT;
                  end else if (resout_pin) begin
                     phase_in   = mps_pkg::PH_IDLE;
                     outcome_in = mps_pkg::OC_UP;
                  end else if (lp_next >= tries) begin
                     loop_in    = lp_next;
                     phase_in   = mps_pkg::PH_IDLE;
                     outcome_in = mps_pkg::OC_UP_TIMEOUT;
                  end else begin
                     loop_in  = lp_next;
                     phase_in = mps_pkg::PH_PU_POLL;
                     delay_in = mps_pkg::at_least_one(cfg.powerup_gap_ticks);
                  end
               end
               mps_pkg::PH_SD_PWRON: begin
                  pins_in.pwron = 1'b1;
                  phase_in      = mps_pkg::PH_SD_ENTER;
                  delay_in      = settle1;
               end
               mps_pkg::PH_SD_ENTER, mps_pkg::PH_SD_WAIT: begin
                  if (phase_ff == mps_pkg::PH_SD_ENTER) begin
                     lp  = 10'd0;
                     ack = 1'b0;
                  end
                  loop_in = lp;
                  ack_in  = ack;
                  if (lp >= limit) begin
                     // wait used up: drop power-on, then retry after reset or fail
                     pins_in.pwron = 1'b0;
                     if (retry_ff) begin
                        phase_in   = mps_pkg::PH_IDLE;
                        outcome_in = mps_pkg::OC_OFF_FAILED;
                     end else begin
                        pins_in.resin = 1'b1;
                        retry_in      = 1'b1;
                        lp            = 10'd0;
                        ack           = 1'b0;
                        loop_in       = 10'd0;
                        ack_in        = 1'b0;
                        limit         = cfg.retry_wait_ticks;
                        if (lp >= limit) begin
                           phase_in   = mps_pkg::PH_IDLE;
                           outcome_in = mps_pkg::OC_OFF_FAILED;
                        end
                     end
                  end
                  if (lp < limit) begin
                     if (!ack && status_pins == mps_pkg::ST_SHUTDOWN_ACK) begin
                        ack_in        = 1'b1;
                        pins_in.pwron = 1'b0;
                     end
                     if (!resout_pin) begin
                        pins_in.pwron = 1'b0;
                        phase_in      = mps_pkg::PH_IDLE;
                        outcome_in    = mps_pkg::OC_OFF;
                     end else begin
                        loop_in  = lp + 10'd1;
                        phase_in = mps_pkg::PH_SD_WAIT;
                        delay_in = 8'd1;
                     end
                  end
               end
               default: begin
                  phase_in = mps_pkg::PH_IDLE;
               end
            endcase
         end
      end
      busy_in = (phase_in != mps_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= mps_pkg::PH_IDLE;
         delay_ff            <= 8'd0;
         loop_ff             <= 10'd0;
         ack_ff              <= 1'b0;
         retry_ff            <= 1'b0;
         pins_ff.host_state  <= mps_pkg::AP_UNDEFINED;
         pins_ff.pwron       <= 1'b0;
         pins_ff.resin       <= 1'b0;
         pins_ff.boot        <= 1'b0;
         pins_ff.boot_driven <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         loop_ff  <= loop_in;
         ack_ff   <= ack_in;
         retry_ff <= retry_in;
         pins_ff  <= pins_in;
      end
   end

endmodule

// File: verif/modem_power_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modem_power_sequencer_tb: self-checking bench for the modem power sequencer
// Drives tick transfers with pin samples and commands, mostly under random sender
// and receiver stalls, predicts every response with a tick-accurate tracker of
// the power sequences and status latches, and compares each response field.
// ----------------------------------------------------------------------------
module modem_power_sequencer_tb;

   // One response: pin levels, busy, outcome and latched modem state
   typedef struct packed {
      logic [2:0] host_state;
      logic       pwron;
      logic       resin;
      logic       boot;
      logic       boot_driven;
      logic       busy;
      logic [2:0] outcome;
      logic [2:0] status;
      logic       powered;
      logic       status_event;
   } pin_snapshot_type;

   // Tracks the sequencer state per tick and holds the responses still owed
   class power_tracker_type;
      mps_pkg::cfg_type  regs;
      logic [2:0]        phase;
      int unsigned       delay_count;
      int unsigned       try_count;
      bit                ack_seen;
      bit                retry_done;
      logic [2:0]        status_latch;
      logic              power_latch;
      bit                holding;
      int unsigned       hold_count;
      int unsigned       hold_tick;
      mps_pkg::pins_type pins;
      pin_snapshot_type  owed_snapshots[$];
      int unsigned       ticks_noted;
      int unsigned       responses_checked;
      int unsigned       errors;
      int unsigned       status_events;
      int unsigned       outcome_seen[8];

      function new();
         regs.boot_mode         = 1'b0;
         regs.first_wait_ticks  = 10'd50;
         regs.retry_wait_ticks  = 10'd70;
         regs.powerup_tries     = 8'd10;
         regs.powerup_gap_ticks = 8'd4;
         regs.settle_ticks      = 8'd1;
         regs.panic_hold_polls  = 8'd100;
         regs.panic_poll_ticks  = 8'd5;
         phase        = mps_pkg::PH_IDLE;
         delay_count  = 0;
         try_count    = 0;
         ack_seen     = 1'b0;
         retry_done   = 1'b0;
         status_latch = mps_pkg::ST_UNDEFINED;
         power_latch  = 1'b0;
         holding      = 1'b0;
         hold_count   = 0;
         hold_tick    = 0;
         pins.host_state  = mps_pkg::AP_UNDEFINED;
         pins.pwron       = 1'b0;
         pins.resin       = 1'b0;
         pins.boot        = 1'b0;
         pins.boot_driven = 1'b0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [9:0] value);
         case (idx)
            mps_pkg::CSR_BOOT_MODE:   regs.boot_mode         = value[0];
            mps_pkg::CSR_FIRST_WAIT:  regs.first_wait_ticks  = value;
            mps_pkg::CSR_RETRY_WAIT:  regs.retry_wait_ticks  = value;
            mps_pkg::CSR_PU_TRIES:    regs.powerup_tries     = value[7:0];
            mps_pkg::CSR_PU_GAP:      regs.powerup_gap_ticks = value[7:0];
            mps_pkg::CSR_SETTLE:      regs.settle_ticks      = value[7:0];
            mps_pkg::CSR_PANIC_POLLS: regs.panic_hold_polls  = value[7:0];
            mps_pkg::CSR_PANIC_TICKS: regs.panic_poll_ticks  = value[7:0];
            default: ;
         endcase
      endfunction

      function int unsigned one_if_zero(logic [7:0] v);
         return (v == 8'd0) ? 32'd1 : 32'(v);
      endfunction

      // One reset-out sample of the power-up confirmation
      function logic [2:0] sample_resout(logic resout);
         if (try_count >= regs.powerup_tries) begin
            phase = mps_pkg::PH_IDLE;
            return mps_pkg::OC_UP_TIMEOUT;
         end
         if (resout) begin
            phase = mps_pkg::PH_IDLE;
            return mps_pkg::OC_UP;
         end
         try_count = (try_count + 1) & 32'h3FF;
         if (try_count >= regs.powerup_tries) begin
            phase = mps_pkg::PH_IDLE;
            return mps_pkg::OC_UP_TIMEOUT;
         end
         phase = mps_pkg::PH_PU_POLL;
         delay_count = one_if_zero(regs.powerup_gap_ticks);
         return mps_pkg::OC_NONE;
      endfunction

      // One poll inside a power-down wait that still has budget
      function logic [2:0] watch_for_loss(logic [2:0] st, logic resout);
         if (!ack_seen && st == mps_pkg::ST_SHUTDOWN_ACK) begin
            ack_seen = 1'b1;
            pins.pwron = 1'b0;
         end
         if (!resout) begin
            pins.pwron = 1'b0;
            phase = mps_pkg::PH_IDLE;
            return mps_pkg::OC_OFF;
         end
         try_count = (try_count + 1) & 32'h3FF;
         phase = mps_pkg::PH_SD_WAIT;
         delay_count = 1;
         return mps_pkg::OC_NONE;
      endfunction

      function logic [2:0] poll_power_loss(logic [2:0] st, logic resout);
         if (try_count < (retry_done ? regs.retry_wait_ticks : regs.first_wait_ticks))
            return watch_for_loss(st, resout);
         pins.pwron = 1'b0;
         if (!retry_done) begin
            // first wait used up: pull reset-in and start the second wait at once
            pins.resin = 1'b1;
            retry_done = 1'b1;
            try_count = 0;
            ack_seen = 1'b0;
            if (regs.retry_wait_ticks != 0)
               return watch_for_loss(st, resout);
         end
         phase = mps_pkg::PH_IDLE;
         return mps_pkg::OC_OFF_FAILED;
      endfunction

      // Status and power latches, with the panic hold after an undefined start
      function bit update_latches(logic [2:0] st, logic resout);
         bit finish;
         bit changed;
         finish = 1'b0;
         if (holding) begin
            if (hold_tick > 1) begin
               hold_tick--;
               return 1'b0;
            end
            if (hold_count > 0) hold_count--;
            if (st != mps_pkg::ST_PANIC || hold_count == 0) finish = 1'b1;
            else hold_tick = one_if_zero(regs.panic_poll_ticks);
         end else if (st != status_latch || resout != power_latch) begin
            if (status_latch == mps_pkg::ST_UNDEFINED && st == mps_pkg::ST_PANIC &&
                regs.panic_hold_polls != 0) begin
               holding = 1'b1;
               hold_count = 32'(regs.panic_hold_polls);
               hold_tick = one_if_zero(regs.panic_poll_ticks);
               return 1'b0;
            end
            finish = 1'b1;
         end
         if (!finish) return 1'b0;
         changed = (st != status_latch || resout != power_latch);
         holding = 1'b0;
         hold_count = 0;
         hold_tick = 0;
         status_latch = st;
         power_latch = resout;
         return changed;
      endfunction

      // Advance one tick and queue the response it must produce
      function void note_tick(logic [1:0] cmd, logic [2:0] st, logic resout);
         pin_snapshot_type s;
         logic [2:0] oc;
         bit ev;
         oc = mps_pkg::OC_NONE;
         ev = update_latches(st, resout);
         if (cmd == mps_pkg::CMD_BAD ||
             (cmd != mps_pkg::CMD_TICK && phase != mps_pkg::PH_IDLE)) begin
            oc = mps_pkg::OC_REJECTED;
         end else if (cmd == mps_pkg::CMD_UP) begin
            pins.boot = regs.boot_mode;
            pins.boot_driven = 1'b1;
            pins.host_state = mps_pkg::AP_NO_BYPASS;
            phase = mps_pkg::PH_PU_RESIN;
            delay_count = one_if_zero(regs.settle_ticks);
         end else if (cmd == mps_pkg::CMD_DOWN) begin
            if (!resout) begin
               oc = mps_pkg::OC_ALREADY_OFF;
            end else begin
               pins.host_state = mps_pkg::AP_SHUTDOWN_REQ;
               ack_seen = 1'b0;
               retry_done = 1'b0;
               phase = mps_pkg::PH_SD_PWRON;
               delay_count = one_if_zero(regs.settle_ticks);
            end
         end else if (phase != mps_pkg::PH_IDLE) begin
            if (delay_count > 1) begin
               delay_count--;
            end else begin
               case (phase)
                  mps_pkg::PH_PU_RESIN: begin
                     pins.resin = 1'b0;
                     phase = mps_pkg::PH_PU_PWRON;
                     delay_count = one_if_zero(regs.settle_ticks);
                  end
                  mps_pkg::PH_PU_PWRON: begin
                     pins.pwron = 1'b1;
                     phase = mps_pkg::PH_PU_PULSE;
                     delay_count = one_if_zero(regs.settle_ticks);
                  end
                  mps_pkg::PH_PU_PULSE: begin
                     pins.pwron = 1'b0;
                     try_count = 0;
                     oc = sample_resout(resout);
                  end
                  mps_pkg::PH_PU_POLL: oc = sample_resout(resout);
                  mps_pkg::PH_SD_PWRON: begin
                     pins.pwron = 1'b1;
                     phase = mps_pkg::PH_SD_ENTER;
                     delay_count = one_if_zero(regs.settle_ticks);
                  end
                  mps_pkg::PH_SD_ENTER: begin
                     try_count = 0;
                     ack_seen = 1'b0;
                     oc = poll_power_loss(st, resout);
                  end
                  mps_pkg::PH_SD_WAIT: oc = poll_power_loss(st, resout);
                  default: phase = mps_pkg::PH_IDLE;
               endcase
            end
         end
         s.host_state   = pins.host_state;
         s.pwron        = pins.pwron;
         s.resin        = pins.resin;
         s.boot         = pins.boot;
         s.boot_driven  = pins.boot_driven;
         s.busy         = (phase != mps_pkg::PH_IDLE);
         s.outcome      = oc;
         s.status       = status_latch;
         s.powered      = power_latch;
         s.status_event = ev;
         owed_snapshots.push_back(s);
         ticks_noted++;
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] response %0d: %s", $time, responses_checked, msg);
      endtask

      task check_field(string name, logic [2:0] got, logic [2:0] want);
         if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
      endtask

      task check_bit(string name, logic got, logic want);
         if (got !== want) report($sformatf("%s is %0b, expected %0b", name, got, want));
      endtask

      task check_response(pin_snapshot_type got);
         pin_snapshot_type want;
         if (owed_snapshots.size() == 0) begin
            report("response transfer with no tick outstanding");
            return;
         end
         want = owed_snapshots.pop_front();
         responses_checked++;
         outcome_seen[want.outcome]++;
         if (want.status_event) status_events++;
         check_field("ap_status_pins", got.host_state, want.host_state);
         check_bit("pwron_pin", got.pwron, want.pwron);
         check_bit("resin_pin", got.resin, want.resin);
         check_bit("boot_pins", got.boot, want.boot);
         check_bit("boot_pins_driven", got.boot_driven, want.boot_driven);
         check_bit("busy_res", got.busy, want.busy);
         check_field("outcome", got.outcome, want.outcome);
         check_field("modem_status", got.status, want.status);
         check_bit("modem_on", got.powered, want.powered);
         check_bit("status_event", got.status_event, want.status_event);
      endtask
   endclass

   localparam int unsigned CYCLE_LIMIT = 200000;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_cmd;
   logic [2:0] req_status_pins;
   logic       req_resout_pin;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_ap_status_pins;
   logic       rsp_pwron_pin;
   logic       rsp_resin_pin;
   logic       rsp_boot_pins;
   logic       rsp_boot_pins_driven;
   logic       rsp_busy_res;
   logic [2:0] rsp_outcome;
   logic [2:0] rsp_modem_status;
   logic       rsp_modem_on;
   logic       rsp_status_event;
   logic       csr_write_en;
   logic [2:0] csr_index;
   logic [9:0] csr_wdata;

   pin_snapshot_type  rsp_seen;
   power_tracker_type board;
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       cycle_count = 0;

   modem_power_sequencer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_status_pins      (req_status_pins),
      .req_resout_pin       (req_resout_pin),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ap_status_pins   (rsp_ap_status_pins),
      .rsp_pwron_pin        (rsp_pwron_pin),
      .rsp_resin_pin        (rsp_resin_pin),
      .rsp_boot_pins        (rsp_boot_pins),
      .rsp_boot_pins_driven (rsp_boot_pins_driven),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_outcome          (rsp_outcome),
      .rsp_modem_status     (rsp_modem_status),
      .rsp_modem_on         (rsp_modem_on),
      .rsp_status_event     (rsp_status_event),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: stall at random on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Gather the response fields in struct order
   assign rsp_seen = {rsp_ap_status_pins, rsp_pwron_pin, rsp_resin_pin, rsp_boot_pins,
                      rsp_boot_pins_driven, rsp_busy_res, rsp_outcome, rsp_modem_status,
                      rsp_modem_on, rsp_status_event};

   // Check every response transfer at the rising edge that completes it
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_seen);
   end

   // Watchdog: abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, board.owed_snapshots.size());
         $display("** modem_power_sequencer: FAILED **");
         $finish;
      end
   end

   // Mostly ordinary status readings, now and then any code at all
   function automatic logic [2:0] calm_status();
      if ($urandom_range(0, 9) == 0) return 3'($urandom_range(0, 7));
      return 3'($urandom_range(1, 5));
   endfunction

   // Offer one tick and hold it until the block takes it. Called and left on a
   // falling edge; the caller's next step assigns req_valid on that same edge.
   task automatic send_tick(input logic [1:0] cmd, input logic [2:0] st, input logic res);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_status_pins <= st;
      req_resout_pin  <= res;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_tick(cmd, st, res);
      @(negedge clock);
   endtask

   // Drop valid and wait out every owed response, plus the block's latency
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (board.owed_snapshots.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input int unsigned value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value[9:0];
      board.set_reg(idx, value[9:0]);
      @(negedge clock);
   endtask

   // Load all eight registers once the block has gone quiet
   task automatic load_settings(input int unsigned boot, input int unsigned first_wait,
                                input int unsigned retry_wait, input int unsigned tries,
                                input int unsigned gap, input int unsigned settle,
                                input int unsigned polls, input int unsigned poll_ticks);
      wait_for_responses();
      write_reg(mps_pkg::CSR_BOOT_MODE, boot);
      write_reg(mps_pkg::CSR_FIRST_WAIT, first_wait);
      write_reg(mps_pkg::CSR_RETRY_WAIT, retry_wait);
      write_reg(mps_pkg::CSR_PU_TRIES, tries);
      write_reg(mps_pkg::CSR_PU_GAP, gap);
      write_reg(mps_pkg::CSR_SETTLE, settle);
      write_reg(mps_pkg::CSR_PANIC_POLLS, polls);
      write_reg(mps_pkg::CSR_PANIC_TICKS, poll_ticks);
      csr_write_en <= 1'b0;
   endtask

   // Random bursts: well-formed power-up, shutdown and panic sequences with
   // random timing, mixed with raw noise. A burst that starts while the last
   // sequence still runs turns into a refused-command case.
   task automatic run_phase(input int unsigned count);
      int unsigned target;
      int unsigned kind;
      int unsigned len;
      int unsigned mark;
      int unsigned ack_at;
      target = board.ticks_noted + count;
      while (board.ticks_noted < target) begin
         kind = $urandom_range(0, 9);
         len  = $urandom_range(4, 30);
         mark = $urandom_range(0, 24);
         if (kind < 3) begin
            // power-up: reset-out rises after a random number of ticks
            send_tick(mps_pkg::CMD_UP, calm_status(), 1'($urandom_range(0, 1)));
            for (int i = 0; i < len; i++)
               send_tick(mps_pkg::CMD_TICK, calm_status(), i >= mark);
         end else if (kind < 6) begin
            // shutdown: acknowledge somewhere, lose power somewhere
            ack_at = $urandom_range(0, 20);
            send_tick(mps_pkg::CMD_DOWN, calm_status(), $urandom_range(0, 7) != 0);
            for (int i = 0; i < len; i++)
               send_tick(mps_pkg::CMD_TICK,
                         (i >= ack_at && i < ack_at + 2) ? mps_pkg::ST_SHUTDOWN_ACK
                                                         : calm_status(),
                         i < mark);
         end else if (kind < 7) begin
            // undefined start, then a run of panic readings, then a non-panic status
            send_tick(mps_pkg::CMD_TICK, mps_pkg::ST_UNDEFINED, 1'($urandom_range(0, 1)));
            for (int i = 0; i < mark / 2 + 1; i++)
               send_tick(mps_pkg::CMD_TICK, mps_pkg::ST_PANIC, 1'($urandom_range(0, 1)));
            send_tick(mps_pkg::CMD_TICK, 3'($urandom_range(1, 7)), 1'($urandom_range(0, 1)));
         end else begin
            for (int i = 0; i < len / 5 + 1; i++)
               send_tick(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
         end
         // now and then hold the sender until every response is back
         if ($urandom_range(0, 7) == 0) wait_for_responses();
      end
   endtask

   initial begin
      board = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = mps_pkg::CMD_TICK;
      req_status_pins = mps_pkg::ST_PANIC;
      req_resout_pin  = 1'b0;
      csr_write_en    = 1'b0;
      csr_index       = mps_pkg::CSR_BOOT_MODE;
      csr_wdata       = 10'd0;
      send_idle_pct   = 8;
      recv_idle_pct   = 71;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: panic hold after the undefined start, at the reset settings
      send_tick(mps_pkg::CMD_TICK, mps_pkg::ST_PANIC, 1'b0);
      send_tick(mps_pkg::CMD_TICK, mps_pkg::ST_PANIC, 1'b1);
      repeat (4) send_tick(mps_pkg::CMD_TICK, 3'd5, 1'b1);
      // refused code, shutdown of a modem that is already off
      send_tick(mps_pkg::CMD_BAD, 3'd5, 1'b1);
      send_tick(mps_pkg::CMD_DOWN, 3'd5, 1'b0);
      // full power-up with one failed sample, and a command refused while busy
      send_tick(mps_pkg::CMD_UP, 3'd1, 1'b0);
      send_tick(mps_pkg::CMD_DOWN, 3'd1, 1'b0);
      send_tick(mps_pkg::CMD_TICK, 3'd1, 1'b0);
      send_tick(mps_pkg::CMD_TICK, 3'd1, 1'b0);
      repeat (4) send_tick(mps_pkg::CMD_TICK, 3'd4, 1'b0);
      send_tick(mps_pkg::CMD_TICK, 3'd3, 1'b1);
      wait_for_responses();
      // shutdown with acknowledgement, then power loss
      send_tick(mps_pkg::CMD_DOWN, 3'd2, 1'b1);
      send_tick(mps_pkg::CMD_TICK, 3'd2, 1'b1);
      send_tick(mps_pkg::CMD_TICK, mps_pkg::ST_SHUTDOWN_ACK, 1'b1);
      send_tick(mps_pkg::CMD_TICK, mps_pkg::ST_SHUTDOWN_ACK, 1'b1);
      send_tick(mps_pkg::CMD_TICK, 3'd2, 1'b0);
      // undefined status with power present, and power-up from there
      send_tick(mps_pkg::CMD_UP, mps_pkg::ST_UNDEFINED, 1'b1);
      send_tick(mps_pkg::CMD_TICK, mps_pkg::ST_UNDEFINED, 1'b1);

      // Random: short waits so both wait paths and both up outcomes show up
      load_settings(1, 3, 4, 4, 2, 1, 3, 2);
      run_phase(120);
      // every delay and limit at zero
      load_settings(0, 0, 0, 0, 0, 0, 0, 0);
      run_phase(70);

      // swap the stall pattern
      send_idle_pct = 71;
      recv_idle_pct = 8;
      load_settings(1, 1000, 1000, 255, 255, 255, 255, 255);
      run_phase(40);
      load_settings($urandom_range(0, 1), $urandom_range(1, 8), $urandom_range(1, 8),
                    $urandom_range(1, 6), $urandom_range(1, 3), $urandom_range(1, 3),
                    $urandom_range(0, 6), $urandom_range(1, 3));
      run_phase(120);

      // no stalls at all
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings($urandom_range(0, 1), $urandom_range(1, 8), $urandom_range(1, 8),
                    $urandom_range(1, 6), $urandom_range(1, 3), $urandom_range(1, 3),
                    $urandom_range(0, 6), $urandom_range(1, 3));
      run_phase(120);
      load_settings(0, 1, 1, 1, 1, 1, 1, 1);
      run_phase(60);

      // Drain, then let the clock run on so that anything stray shows
      wait_for_responses();
      repeat (4) @(posedge clock);

      $display("%0d ticks checked: %0d up, %0d up timeouts, %0d off, %0d off failed",
               board.responses_checked, board.outcome_seen[mps_pkg::OC_UP],
               board.outcome_seen[mps_pkg::OC_UP_TIMEOUT], board.outcome_seen[mps_pkg::OC_OFF],
               board.outcome_seen[mps_pkg::OC_OFF_FAILED]);
      $display("%0d already off, %0d refused, %0d latch changes, %0d mismatches",
               board.outcome_seen[mps_pkg::OC_ALREADY_OFF],
               board.outcome_seen[mps_pkg::OC_REJECTED],
               board.status_events, board.errors);
      if (board.errors == 0) begin
         $display("** modem_power_sequencer: PASSED **");
      end else begin
         $display("** modem_power_sequencer: FAILED **");
      end
      $finish;
   end

endmodule

// File: files.f
design/mps_pkg.sv
design/mps_csr.sv
design/mps_latch.sv
design/mps_seq.sv
design/modem_power_sequencer.sv
verif/modem_power_sequencer_tb.sv
